/* rtl/assert_macros.svh */
// Assertion helpers used by the datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define CHK_HOLDS(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error("invariant violated");

// When the first expression holds, the second holds in the cycle after.
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("sequence violated");

`endif

/* rtl/pts_pkg.sv */
package pts_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 8;
	localparam int unsigned MAX_RESULTS = 8;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_ADD     = 2'd1,
		OP_DEL     = 2'd2,
		OP_SERVICE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_ADDED      = 3'd0,
		ST_UPDATED    = 3'd1,
		ST_FULL       = 3'd2,
		ST_REMOVED    = 3'd3,
		ST_NOT_FOUND  = 3'd4,
		ST_TICK_DONE  = 3'd5,
		ST_DISPATCHED = 3'd6,
		ST_NONE_READY = 3'd7
	} status_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  task_id;
		logic [15:0] first_delay;
		logic [15:0] run_period;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] task_out;
		logic       was_one_shot;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] countdown;
		logic [15:0] period;
		logic        ready;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_TK_RD,
		S_TK_EX,
		S_AD_RD,
		S_AD_EX,
		S_DL_RD,
		S_DL_EX,
		S_DL_MV,
		S_SV_RD,
		S_SV_EX,
		S_SV_MV,
		S_SV_END,
		S_FIN
	} state_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_TICK,
		WR_NEW,
		WR_APPEND,
		WR_MOVE,
		WR_RELOAD
	} wr_sel_t;

	typedef enum logic [1:0] {
		OUT_NONE,
		OUT_PEND_MORE,
		OUT_PEND_LAST,
		OUT_FINAL
	} out_sel_t;

	typedef struct packed {
		logic     load_item;
		logic     rd_cur;
		logic     rd_last;
		logic     inc_i;
		logic     cnt_inc;
		logic     cnt_dec;
		logic     pend_load;
		wr_sel_t  wr_sel;
		out_sel_t out_sel;
		status_t  status;
	} ctl_cmd_t;

	typedef struct packed {
		logic i_end;
		logic n_full;
		logic id_match;
		logic ent_ready;
		logic one_shot;
		logic i_last;
		logic tbl_full;
		logic out_free;
		logic pend_valid;
	} dp_stat_t;

endpackage

/* rtl/pts_datapath.sv */
`include "assert_macros.svh"

module pts_datapath import pts_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  item_t    item,
	input  ctl_cmd_t cmd,
	output dp_stat_t stat,
	output logic     result_valid,
	input  logic     result_ready,
	output result_t  result
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned NW = $clog2(MAX_RESULTS + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam logic [NW-1:0] NMAX_C = NW'(MAX_RESULTS);

	entry_t        mem [TABLE_DEPTH];
	entry_t        rdata_q;
	item_t         item_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] lastidx;
	logic [NW-1:0] n_q;
	logic          pend_valid_q;
	logic [7:0]    pend_id_q;
	logic          pend_one_q;
	logic          result_valid_q;
	result_t       result_q;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;
	logic          push;

	assign lastidx = cnt_q - CW'(1);
	assign rd_en   = cmd.rd_cur | cmd.rd_last;
	assign rd_addr = cmd.rd_last ? lastidx[AW-1:0] : idx_q[AW-1:0];
	assign push    = (cmd.out_sel != OUT_NONE);

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = idx_q[AW-1:0];
		wr_data = rdata_q;
		unique case (cmd.wr_sel)
			WR_NONE: begin
				wr_en = 1'b0;
			end
			WR_TICK: begin
				// A due entry stays at zero and is marked ready.
				if (rdata_q.countdown == 16'd0) begin
					wr_data.ready = 1'b1;
				end else begin
					wr_data.countdown = rdata_q.countdown - 16'd1;
				end
			end
			WR_NEW: begin
				wr_data = '{id: item_q.task_id, countdown: item_q.first_delay,
					period: item_q.run_period, ready: 1'b0};
			end
			WR_APPEND: begin
				wr_addr = cnt_q[AW-1:0];
				wr_data = '{id: item_q.task_id, countdown: item_q.first_delay,
					period: item_q.run_period, ready: 1'b0};
			end
			WR_MOVE: begin
				wr_data = rdata_q;
			end
			WR_RELOAD: begin
				wr_data.countdown = rdata_q.period;
				wr_data.ready     = 1'b0;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= item;
		end
		if (cmd.pend_load) begin
			pend_id_q  <= rdata_q.id;
			pend_one_q <= (rdata_q.period == 16'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			idx_q        <= '0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= lastidx;
			end
			if (cmd.load_item) begin
				idx_q <= '0;
			end else if (cmd.inc_i) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.load_item) begin
				n_q <= '0;
			end else if (cmd.pend_load) begin
				n_q <= n_q + NW'(1);
			end
			if (cmd.load_item) begin
				pend_valid_q <= 1'b0;
			end else if (cmd.pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.out_sel == OUT_PEND_LAST) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// Output register: a beat waits here while the sequencer moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (push) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			unique case (cmd.out_sel)
				OUT_PEND_MORE, OUT_PEND_LAST: begin
					result_q.status       <= ST_DISPATCHED;
					result_q.task_out     <= pend_id_q;
					result_q.was_one_shot <= pend_one_q;
					result_q.last         <= (cmd.out_sel == OUT_PEND_LAST);
				end
				default: begin
					result_q.status       <= cmd.status;
					result_q.task_out     <= (cmd.status == ST_TICK_DONE ||
						cmd.status == ST_NONE_READY) ? 8'd0 : item_q.task_id;
					result_q.was_one_shot <= 1'b0;
					result_q.last         <= 1'b1;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign stat.i_end      = (idx_q >= cnt_q);
	assign stat.n_full     = (n_q >= NMAX_C);
	assign stat.id_match   = (rdata_q.id == item_q.task_id);
	assign stat.ent_ready  = rdata_q.ready;
	assign stat.one_shot   = (rdata_q.period == 16'd0);
	assign stat.i_last     = (idx_q == lastidx);
	assign stat.tbl_full   = (cnt_q >= DEPTH_C);
	assign stat.out_free   = !result_valid_q || result_ready;
	assign stat.pend_valid = pend_valid_q;

	`CHK_HOLDS(a_cnt_range, clk, arst_n, cnt_q <= DEPTH_C)
	`CHK_HOLDS(a_rd_in_table, clk, arst_n, !cmd.rd_cur || (idx_q < cnt_q))
	`CHK_HOLDS(a_dispatch_cap, clk, arst_n, !cmd.pend_load || (n_q < NMAX_C))
	`CHK_HOLDS(a_no_overwrite, clk, arst_n, !push || !result_valid_q || result_ready)
	`CHK_NEXT(a_dec_empties, clk, arst_n, cmd.cnt_dec && (cnt_q == CW'(1)), cnt_q == '0)

endmodule

/* rtl/pts_controller.sv */
module pts_controller import pts_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  op_t      opcode,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	state_t  state_q, state_d;
	status_t res_q, res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= ST_ADDED;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		res_d         = res_q;
		item_ready    = (state_q == S_IDLE);
		cmd.load_item = 1'b0;
		cmd.rd_cur    = 1'b0;
		cmd.rd_last   = 1'b0;
		cmd.inc_i     = 1'b0;
		cmd.cnt_inc   = 1'b0;
		cmd.cnt_dec   = 1'b0;
		cmd.pend_load = 1'b0;
		cmd.wr_sel    = WR_NONE;
		cmd.out_sel   = OUT_NONE;
		cmd.status    = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load_item = 1'b1;
					unique case (opcode)
						OP_TICK:    state_d = S_TK_RD;
						OP_ADD:     state_d = S_AD_RD;
						OP_DEL:     state_d = S_DL_RD;
						OP_SERVICE: state_d = S_SV_RD;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_TK_RD: begin
				if (stat.i_end) begin
					res_d   = ST_TICK_DONE;
					state_d = S_FIN;
				end else begin
					cmd.rd_cur = 1'b1;
					state_d    = S_TK_EX;
				end
			end
			S_TK_EX: begin
				cmd.wr_sel = WR_TICK;
				cmd.inc_i  = 1'b1;
				state_d    = S_TK_RD;
			end
			S_AD_RD: begin
				if (stat.i_end) begin
					if (stat.tbl_full) begin
						res_d = ST_FULL;
					end else begin
						cmd.wr_sel  = WR_APPEND;
						cmd.cnt_inc = 1'b1;
						res_d       = ST_ADDED;
					end
					state_d = S_FIN;
				end else begin
					cmd.rd_cur = 1'b1;
					state_d    = S_AD_EX;
				end
			end
			S_AD_EX: begin
				if (stat.id_match) begin
					cmd.wr_sel = WR_NEW;
					res_d      = ST_UPDATED;
					state_d    = S_FIN;
				end else begin
					cmd.inc_i = 1'b1;
					state_d   = S_AD_RD;
				end
			end
			S_DL_RD: begin
				if (stat.i_end) begin
					res_d   = ST_NOT_FOUND;
					state_d = S_FIN;
				end else begin
					cmd.rd_cur = 1'b1;
					state_d    = S_DL_EX;
				end
			end
			S_DL_EX: begin
				if (stat.id_match) begin
					if (stat.i_last) begin
						cmd.cnt_dec = 1'b1;
						res_d       = ST_REMOVED;
						state_d     = S_FIN;
					end else begin
						cmd.rd_last = 1'b1;
						state_d     = S_DL_MV;
					end
				end else begin
					cmd.inc_i = 1'b1;
					state_d   = S_DL_RD;
				end
			end
			S_DL_MV: begin
				cmd.wr_sel  = WR_MOVE;
				cmd.cnt_dec = 1'b1;
				res_d       = ST_REMOVED;
				state_d     = S_FIN;
			end
			S_SV_RD: begin
				if (stat.i_end || stat.n_full) begin
					state_d = S_SV_END;
				end else begin
					cmd.rd_cur = 1'b1;
					state_d    = S_SV_EX;
				end
			end
			S_SV_EX: begin
				// A dispatch is held back one step so that its last flag is known
				// when it leaves; the held beat goes out as the next one arrives.
				if (!stat.ent_ready) begin
					cmd.inc_i = 1'b1;
					state_d   = S_SV_RD;
				end else if (!stat.pend_valid || stat.out_free) begin
					if (stat.pend_valid) begin
						cmd.out_sel = OUT_PEND_MORE;
					end
					cmd.pend_load = 1'b1;
					if (stat.one_shot) begin
						if (stat.i_last) begin
							cmd.cnt_dec = 1'b1;
							state_d     = S_SV_RD;
						end else begin
							cmd.rd_last = 1'b1;
							state_d     = S_SV_MV;
						end
					end else begin
						cmd.wr_sel = WR_RELOAD;
						cmd.inc_i  = 1'b1;
						state_d    = S_SV_RD;
					end
				end
			end
			S_SV_MV: begin
				// The moved entry lands in the current slot and is examined next.
				cmd.wr_sel  = WR_MOVE;
				cmd.cnt_dec = 1'b1;
				state_d     = S_SV_RD;
			end
			S_SV_END: begin
				if (stat.out_free) begin
					if (stat.pend_valid) begin
						cmd.out_sel = OUT_PEND_LAST;
					end else begin
						cmd.out_sel = OUT_FINAL;
						cmd.status  = ST_NONE_READY;
					end
					state_d = S_IDLE;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.out_sel = OUT_FINAL;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/periodic_task_scheduler_table_unit.sv */
// Channel   Direction  Handshake                    Payload
// item      in         item_valid / item_ready      item_t (opcode, task_id, delays)
// result    out        result_valid / result_ready  result_t (status, task_out, flags)
//
// One item is in work at a time; item_ready is high only between items.
// The task table is a single-port memory, so the scan takes each entry in
// a read step and then an examine or write-back step; delete and a service
// pass add a move step when a removed entry is not the last. Reset clears
// the entry count and control state only, not the table; no clearing pass.
// A full result register stalls the scan only at the step that must emit.
module periodic_task_scheduler_table_unit import pts_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	pts_controller u_ctl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.opcode     (op_t'(item.opcode)),
		.stat       (stat),
		.cmd        (cmd)
	);

	pts_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
